// File: rtl/core/drr_pkg.sv
`timescale 1ns / 1ps

package drr_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT_LOG2 = 2'd1;

  localparam logic [31:0] BASE_ADDRESS_RESET    = 32'd0;
  localparam logic [4:0]  SLOT_COUNT_LOG2_RESET = 5'd10;

  localparam logic MODE_RESTART  = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] hw_count;
    logic [23:0] consumer_tail;
  } in_t;

  typedef struct packed {
    logic [5:0]  desc_index;
    logic [31:0] slot_addr;
    logic        write_valid;
    logic [23:0] head_slot;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SIZE,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic size;
    logic emit;
    logic empty;
  } cmd_t;

  typedef struct packed {
    logic none;
    logic final_item;
  } status_t;

endpackage

// File: rtl/core/drr_ctrl.sv
`timescale 1ns / 1ps

module drr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  drr_pkg::status_t status,
  output drr_pkg::cmd_t    cmd
);

  drr_pkg::state_t state;
  drr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      drr_pkg::ST_IDLE: begin
        if (start) state_next = drr_pkg::ST_PREP;
      end
      drr_pkg::ST_PREP: begin
        state_next = drr_pkg::ST_SIZE;
      end
      drr_pkg::ST_SIZE: begin
        state_next = status.none ? drr_pkg::ST_EMPTY : drr_pkg::ST_EMIT;
      end
      drr_pkg::ST_EMIT: begin
        if (status.final_item) state_next = drr_pkg::ST_IDLE;
      end
      drr_pkg::ST_EMPTY: begin
        state_next = drr_pkg::ST_IDLE;
      end
      default: begin
        state_next = drr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      drr_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      drr_pkg::ST_PREP:  cmd.prep  = 1'b1;
      drr_pkg::ST_SIZE:  cmd.size  = 1'b1;
      drr_pkg::ST_EMIT:  cmd.emit  = 1'b1;
      drr_pkg::ST_EMPTY: cmd.empty = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/drr_datapath.sv
`timescale 1ns / 1ps

module drr_datapath #(
  parameter int BUF_SIZE_LOG2 = 11,
  parameter int RING_SIZE     = 16,
  parameter int SLOT_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  drr_pkg::cmd_t                       cmd,
  output drr_pkg::status_t                    status,
  input  drr_pkg::in_t                        request,
  input  logic                                cfg_valid,
  input  logic [drr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [31:0]                         cfg_data,
  output drr_pkg::out_t                       result,
  output logic                                result_valid
);

  localparam int RW = $clog2(RING_SIZE);
  localparam int CW = $clog2(RING_SIZE + 1);

  // configuration
  logic [31:0] base_address;
  logic [4:0]  slot_count_log2;

  // item latched at accept
  logic                 mode;
  logic [31:0]          hw_count;
  logic [SLOT_BITS-1:0] ctail;
  logic [SLOT_BITS-1:0] mask;
  logic                 is_refill;

  // intermediate results
  logic [31:0]          delta;
  logic [SLOT_BITS-1:0] space;

  // ring state
  logic [31:0]          last_hw_count;
  logic [SLOT_BITS-1:0] readable_head;
  logic [SLOT_BITS-1:0] next_fill_slot;
  logic [RW-1:0]        ring_tail;

  // emission
  logic [RW-1:0] desc_idx;
  logic [CW-1:0] remaining;

  logic [4:0]           lg_c;
  logic [SLOT_BITS-1:0] mask_c;
  logic [31:0]          min_c;
  logic [CW-1:0]        n_c;
  logic [RW-1:0]        desc_idx_next;
  logic [31:0]          slot_addr_c;

  always_comb begin
    if (slot_count_log2 < 5'd1) begin
      lg_c = 5'd1;
    end else if (slot_count_log2 > 5'(SLOT_BITS)) begin
      lg_c = 5'(SLOT_BITS);
    end else begin
      lg_c = slot_count_log2;
    end
    for (int j = 0; j < SLOT_BITS; j++) begin
      mask_c[j] = (32'(j) < 32'(lg_c));
    end
  end

  // min(space, delta, RING_SIZE)
  always_comb begin
    min_c = (32'(space) < delta) ? 32'(space) : delta;
    n_c   = (min_c > 32'(RING_SIZE)) ? CW'(RING_SIZE) : min_c[CW-1:0];
  end

  assign is_refill     = (mode == drr_pkg::MODE_COMPLETE);
  assign desc_idx_next = (desc_idx == RW'(RING_SIZE - 1)) ? '0 : desc_idx + 1'b1;
  assign slot_addr_c   = base_address + (32'(next_fill_slot) << BUF_SIZE_LOG2);

  assign status.none       = is_refill && (n_c == '0);
  assign status.final_item = (remaining == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= drr_pkg::BASE_ADDRESS_RESET;
      slot_count_log2 <= drr_pkg::SLOT_COUNT_LOG2_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        drr_pkg::CFG_BASE_ADDRESS:    base_address    <= cfg_data;
        drr_pkg::CFG_SLOT_COUNT_LOG2: slot_count_log2 <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= request.mode;
      hw_count <= request.hw_count;
      ctail    <= request.consumer_tail[SLOT_BITS-1:0];
      mask     <= mask_c;
    end
    if (cmd.prep) begin
      delta <= hw_count - last_hw_count;
      space <= ((ctail & mask) - next_fill_slot - 1'b1) & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_hw_count  <= '0;
      readable_head  <= '0;
      next_fill_slot <= '0;
      ring_tail      <= '0;
    end else begin
      if (cmd.prep && !is_refill) begin
        last_hw_count  <= '0;
        readable_head  <= '0;
        next_fill_slot <= '0;
        ring_tail      <= '0;
      end
      if (cmd.size && is_refill) begin
        last_hw_count <= hw_count;
        readable_head <= (readable_head + delta[SLOT_BITS-1:0]) & mask;
      end
      if (cmd.emit) begin
        next_fill_slot <= (next_fill_slot + 1'b1) & mask;
        // restart fills from ring position 0 and leaves the tail there
        if (is_refill) ring_tail <= desc_idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      desc_idx  <= is_refill ? ring_tail : '0;
      remaining <= is_refill ? n_c : CW'(RING_SIZE);
    end else if (cmd.emit) begin
      desc_idx  <= desc_idx_next;
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.desc_index  <= 6'(desc_idx);
      result.slot_addr   <= slot_addr_c;
      result.write_valid <= 1'b1;
      result.head_slot   <= 24'(readable_head);
      result.last        <= status.final_item;
    end else if (cmd.empty) begin
      result.desc_index  <= '0;
      result.slot_addr   <= '0;
      result.write_valid <= 1'b0;
      result.head_slot   <= 24'(readable_head);
      result.last        <= 1'b1;
    end
  end

endmodule

// File: rtl/core/dma_descriptor_ring_refill_unit.sv
`timescale 1ns / 1ps
// Receive descriptor ring refill unit.
// Raise start with a request while busy is low: the item is taken at that
// edge and busy stays high until its results are out. A restart request
// (mode 0) clears all pointers and writes all RING_SIZE descriptors from
// slot 0. A completion request (mode 1) advances the readable head by the
// change in hw_count and writes up to RING_SIZE descriptors at the ring tail,
// limited by the free space before consumer_tail and by that change.
// Each result is shown on result for one cycle with result_valid high; the
// final one of an item has last set. A completion that writes nothing gives
// one result with write_valid low. The receiver cannot stall the results.
// Sequence: a prep step works out the count delta and the free space, a size
// step the number of writes, then one descriptor result is written per cycle
// with no gaps until the last.
// Configuration: index 0 base_address, index 1 slot_count_log2; cfg_ready
// follows !busy, so writes go in only while busy is low.
// Reset (rst, synchronous) clears all pointers and loads the register resets.
module dma_descriptor_ring_refill_unit #(
  parameter int BUF_SIZE_LOG2 = 11,
  parameter int RING_SIZE     = 16,
  parameter int SLOT_BITS     = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  drr_pkg::in_t                    request,
  output drr_pkg::out_t                   result,
  output logic                            result_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  drr_pkg::cmd_t    cmd;
  drr_pkg::status_t status;

  assign cfg_ready = !busy;

  drr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  drr_datapath #(
    .BUF_SIZE_LOG2 (BUF_SIZE_LOG2),
    .RING_SIZE     (RING_SIZE),
    .SLOT_BITS     (SLOT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .request      (request),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_result_in_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without an item in progress");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_valid |-> result.last)
    else $error("result without a write is not final");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("gap inside a burst of descriptor writes");

endmodule
